// ===== rtl/core/icv_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the image CRC verifier.
package icv_pkg;

    localparam int unsigned LEN_W  = 24;
    localparam int unsigned ADDR_W = 24;
    localparam int unsigned CRC_W  = 32;
    localparam int unsigned CFG_W  = 32;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

    localparam logic [LEN_W-1:0]  MAX_IMAGE_BYTES_DEF   = 24'd262144;
    localparam logic [ADDR_W-1:0] SLOT_BASE_ADDRESS_DEF = 24'd0;

    typedef enum logic [1:0] {
        REG_IMAGE_LENGTH = 2'd0,
        REG_EXPECTED_CRC = 2'd1,
        REG_SLOT_ADDRESS = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        VERDICT_MATCH      = 2'd0,
        VERDICT_MISMATCH   = 2'd1,
        VERDICT_BAD_CONFIG = 2'd2,
        VERDICT_READ_FAULT = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       read_fault;
    } in_word_t;

    typedef struct packed {
        verdict_t         verdict;
        logic [CRC_W-1:0] computed_crc;
    } out_word_t;

    typedef struct packed {
        logic             bad_config;
        logic [LEN_W-1:0] image_length;
        logic [CRC_W-1:0] expected_crc;
    } cfg_status_t;

    // reflected CRC-32, one byte, LSB first
    function automatic logic [CRC_W-1:0] crc32_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [7:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/image_crc32_verifier.sv =====
// Top level of the image CRC-32 verifier.
// A result word is registered in the cycle after the byte word that gives it.
// Throughput: one byte word per cycle when s_ready is high; the byte-wide CRC
// update and count compare sit between the input port and result register.
// s_ready drops only while a result waits and m_ready is low.
// Synchronous active-low reset: config registers to zero, CRC to all ones,
// count to zero, no result pending.
module image_crc32_verifier #(
    parameter logic [icv_pkg::LEN_W-1:0]  MAX_IMAGE_BYTES   = icv_pkg::MAX_IMAGE_BYTES_DEF,
    parameter logic [icv_pkg::ADDR_W-1:0] SLOT_BASE_ADDRESS = icv_pkg::SLOT_BASE_ADDRESS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  icv_pkg::reg_index_t       cfg_addr,
    input  logic [icv_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  icv_pkg::in_word_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output icv_pkg::out_word_t        m_data
);

    icv_pkg::cfg_status_t cfg_status;

    icv_cfg #(
        .MAX_IMAGE_BYTES   (MAX_IMAGE_BYTES),
        .SLOT_BASE_ADDRESS (SLOT_BASE_ADDRESS)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .cfg_status (cfg_status)
    );

    icv_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_status (cfg_status),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== rtl/core/icv_cfg.sv =====
// Configuration registers and the length / slot address check.
module icv_cfg #(
    parameter logic [icv_pkg::LEN_W-1:0]  MAX_IMAGE_BYTES   = icv_pkg::MAX_IMAGE_BYTES_DEF,
    parameter logic [icv_pkg::ADDR_W-1:0] SLOT_BASE_ADDRESS = icv_pkg::SLOT_BASE_ADDRESS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  icv_pkg::reg_index_t       cfg_addr,
    input  logic [icv_pkg::CFG_W-1:0] cfg_wdata,
    output icv_pkg::cfg_status_t      cfg_status
);

    logic [icv_pkg::LEN_W-1:0]  image_length_reg;
    logic [icv_pkg::CRC_W-1:0]  expected_crc_reg;
    logic [icv_pkg::ADDR_W-1:0] slot_address_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_length_reg <= '0;
            expected_crc_reg <= '0;
            slot_address_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                icv_pkg::REG_IMAGE_LENGTH: image_length_reg <= cfg_wdata[icv_pkg::LEN_W-1:0];
                icv_pkg::REG_EXPECTED_CRC: expected_crc_reg <= cfg_wdata[icv_pkg::CRC_W-1:0];
                icv_pkg::REG_SLOT_ADDRESS: slot_address_reg <= cfg_wdata[icv_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg_status.image_length = image_length_reg;
        cfg_status.expected_crc = expected_crc_reg;
        cfg_status.bad_config   = (image_length_reg == '0) ||
                                  (image_length_reg > MAX_IMAGE_BYTES) ||
                                  (slot_address_reg != SLOT_BASE_ADDRESS);
    end

endmodule

// ===== rtl/core/icv_core.sv =====
// CRC and byte count state with the registered result word.
module icv_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  icv_pkg::cfg_status_t cfg_status,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  icv_pkg::in_word_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output icv_pkg::out_word_t   m_data
);

    logic [icv_pkg::CRC_W-1:0] crc_reg, crc_next;
    logic [icv_pkg::LEN_W-1:0] count_reg, count_next;
    logic                      m_valid_reg, m_valid_next;
    icv_pkg::out_word_t        m_word_reg, m_word_next;

    logic                      accept;
    logic [icv_pkg::CRC_W-1:0] crc_upd;
    logic [icv_pkg::CRC_W-1:0] crc_final;
    logic [icv_pkg::LEN_W-1:0] count_upd;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_word_reg;

    assign crc_upd   = icv_pkg::crc32_byte(crc_reg, s_data.data_byte);
    assign crc_final = crc_upd ^ icv_pkg::CRC_ONES;
    assign count_upd = count_reg + 1'b1;

    always_comb begin
        crc_next     = crc_reg;
        count_next   = count_reg;
        m_word_next  = m_word_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (accept) begin
            if (cfg_status.bad_config) begin
                crc_next                 = icv_pkg::CRC_ONES;
                count_next               = '0;
                m_valid_next             = 1'b1;
                m_word_next.verdict      = icv_pkg::VERDICT_BAD_CONFIG;
                m_word_next.computed_crc = '0;
            end else if (s_data.read_fault) begin
                crc_next                 = icv_pkg::CRC_ONES;
                count_next               = '0;
                m_valid_next             = 1'b1;
                m_word_next.verdict      = icv_pkg::VERDICT_READ_FAULT;
                m_word_next.computed_crc = '0;
            end else if (count_upd >= cfg_status.image_length) begin
                crc_next                 = icv_pkg::CRC_ONES;
                count_next               = '0;
                m_valid_next             = 1'b1;
                m_word_next.verdict      = (crc_final == cfg_status.expected_crc) ?
                                           icv_pkg::VERDICT_MATCH :
                                           icv_pkg::VERDICT_MISMATCH;
                m_word_next.computed_crc = crc_final;
            end else begin
                crc_next   = crc_upd;
                count_next = count_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg     <= icv_pkg::CRC_ONES;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            crc_reg     <= crc_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
    end

    a_bad_cfg_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cfg_status.bad_config |=>
            m_valid_reg && m_word_reg.verdict == icv_pkg::VERDICT_BAD_CONFIG &&
            m_word_reg.computed_crc == '0)
        else $error("bad configuration word did not give a failure result");

    a_fault_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !cfg_status.bad_config && s_data.read_fault |=>
            m_valid_reg && m_word_reg.verdict == icv_pkg::VERDICT_READ_FAULT)
        else $error("read fault word did not give a read fault result");

    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && m_valid_next |=> crc_reg == icv_pkg::CRC_ONES && count_reg == '0)
        else $error("run state not cleared after a result");

    a_fail_crc_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_word_reg.verdict == icv_pkg::VERDICT_BAD_CONFIG ||
                        m_word_reg.verdict == icv_pkg::VERDICT_READ_FAULT) |->
            m_word_reg.computed_crc == '0)
        else $error("failure result carries a nonzero CRC");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_word_reg))
        else $error("pending result overwritten");

endmodule
